// ===== hdl/lfsr_reverse_position_search_macros.svh =====
// Assertion macros for the LFSR reverse position search block.
`ifndef LFSR_REVERSE_POSITION_SEARCH_MACROS_SVH
`define LFSR_REVERSE_POSITION_SEARCH_MACROS_SVH

`ifndef NO_ASSERTIONS

`define LRPS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define LRPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LRPS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)

`define LRPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hdl/lrps_pkg.sv =====
// Shared constants, tables and types of the LFSR reverse position search block.
`default_nettype none

package lrps_pkg;

    localparam int LFSR_WIDTH       = 17;
    localparam int CHECKPOINT_COUNT = 16;
    localparam int SPACING_LOG2     = 13;
    localparam int POLY_COUNT       = 4;
    localparam int SEL_WIDTH        = $clog2(POLY_COUNT);
    localparam int MARK_WIDTH       = $clog2(CHECKPOINT_COUNT);

    typedef logic [LFSR_WIDTH-1:0] t_state;
    typedef logic [SEL_WIDTH-1:0]  t_sel;
    typedef logic [MARK_WIDTH-1:0] t_mark;

    localparam t_state STATE_MAX = {LFSR_WIDTH{1'b1}};
    localparam t_state SEED      = t_state'(1);

    localparam t_state POLY_TAB [POLY_COUNT] = '{
        17'h1D258, 17'h17E04, 17'h1FF6B, 17'h13F67
    };

    localparam t_state MARK_TAB [POLY_COUNT][CHECKPOINT_COUNT] = '{
        '{17'h00001, 17'h1559D, 17'h1155A, 17'h19902, 17'h0CB1F, 17'h1235E, 17'h1465F,
          17'h1E2B1, 17'h1719B, 17'h14D1E, 17'h19B10, 17'h08B9F, 17'h1CAF5, 17'h093B7,
          17'h1B99D, 17'h10D6B},
        '{17'h00001, 17'h1A1BE, 17'h16F3C, 17'h1856F, 17'h05C6E, 17'h08634, 17'h0229E,
          17'h14BD1, 17'h13021, 17'h0E6D6, 17'h04743, 17'h17685, 17'h06536, 17'h08FE6,
          17'h11A3B, 17'h0799C},
        '{17'h00001, 17'h036C4, 17'h0BA96, 17'h1966A, 17'h0E3DA, 17'h16CFA, 17'h16381,
          17'h112E9, 17'h004EB, 17'h0C57B, 17'h0706F, 17'h15738, 17'h0FD7F, 17'h087AA,
          17'h09703, 17'h02DEE},
        '{17'h00001, 17'h1B796, 17'h1880D, 17'h1C616, 17'h03E8C, 17'h182F3, 17'h13B8A,
          17'h01678, 17'h07885, 17'h09E54, 17'h0B4B3, 17'h1FA8C, 17'h06ADF, 17'h0ECAB,
          17'h021A2, 17'h02FAE}
    };

    typedef struct packed {
        logic load;
        logic step;
        logic capture;
    } t_cmd;

    typedef struct packed {
        logic finish;
    } t_status;

endpackage

`default_nettype wire

// ===== hdl/lrps_datapath.sv =====
// Datapath: search state, backward LFSR step, checkpoint compare and result register.
`default_nettype none

module lrps_datapath (
    input  wire                     i_clk,
    input  wire  lrps_pkg::t_cmd    i_cmd,
    input  wire  lrps_pkg::t_sel    i_poly_index,
    input  wire  lrps_pkg::t_state  i_lfsr_state,
    output lrps_pkg::t_status       o_status,
    output logic [lrps_pkg::LFSR_WIDTH-1:0] o_step_count,
    output logic                    o_invalid
);

    lrps_pkg::t_state r_state;
    lrps_pkg::t_state r_count;
    lrps_pkg::t_sel   r_sel;
    logic             r_first;
    lrps_pkg::t_state r_out_count;
    logic             r_out_invalid;

    lrps_pkg::t_state w_poly;
    lrps_pkg::t_state w_shift;
    logic             w_fb;
    lrps_pkg::t_state w_next;
    logic             w_hit;
    lrps_pkg::t_mark  w_hit_idx;
    logic             w_finish;
    lrps_pkg::t_state w_res_count;
    logic             w_res_invalid;

    always_comb begin
        w_poly  = lrps_pkg::POLY_TAB[r_sel];
        w_shift = r_state >> 1;
        w_fb    = (^(w_shift & w_poly)) ^ r_state[0];
        w_next  = {w_fb, w_shift[lrps_pkg::LFSR_WIDTH-2:0]};
    end

    // The lowest matching checkpoint wins, so the search runs from the top down.
    always_comb begin
        w_hit     = 1'b0;
        w_hit_idx = '0;
        for (int k = lrps_pkg::CHECKPOINT_COUNT - 1; k >= 1; k--) begin
            if (r_state == lrps_pkg::MARK_TAB[r_sel][k]) begin
                w_hit     = 1'b1;
                w_hit_idx = lrps_pkg::t_mark'(k);
            end
        end
    end

    always_comb begin
        w_finish      = 1'b0;
        w_res_count   = '0;
        w_res_invalid = 1'b0;
        if (r_first) begin
            if (r_state == '0) begin
                w_finish      = 1'b1;
                w_res_invalid = 1'b1;
            end else if (r_state == lrps_pkg::SEED) begin
                w_finish = 1'b1;
            end
        end else begin
            if (w_hit) begin
                w_finish    = 1'b1;
                w_res_count = r_count
                    + lrps_pkg::t_state'({w_hit_idx, {lrps_pkg::SPACING_LOG2{1'b0}}})
                    - lrps_pkg::t_state'(1);
            end else if (r_state == lrps_pkg::SEED) begin
                w_finish    = 1'b1;
                w_res_count = r_count;
            end else if (r_count == lrps_pkg::STATE_MAX) begin
                w_finish      = 1'b1;
                w_res_invalid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_state <= i_lfsr_state;
            r_sel   <= i_poly_index;
            r_count <= '0;
            r_first <= 1'b1;
        end else if (i_cmd.step) begin
            r_state <= w_next;
            r_count <= r_count + lrps_pkg::t_state'(1);
            r_first <= 1'b0;
        end
        if (i_cmd.capture) begin
            r_out_count   <= w_res_count;
            r_out_invalid <= w_res_invalid;
        end
    end

    assign o_status.finish = w_finish;
    assign o_step_count    = r_out_count;
    assign o_invalid       = r_out_invalid;

endmodule

`default_nettype wire

// ===== hdl/lrps_ctrl.sv =====
// Controller: input and output handshakes and sequencing of the search.
`default_nettype none

module lrps_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    output logic                o_valid,
    input  wire                 i_ready,
    input  wire lrps_pkg::t_status i_status,
    output lrps_pkg::t_cmd      o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic r_fsm;
    logic n_fsm;
    logic r_out_valid;
    logic n_out_valid;
    logic w_out_free;

    assign w_out_free = !r_out_valid || i_ready;

    always_comb begin
        n_fsm       = r_fsm;
        n_out_valid = r_out_valid && !i_ready;
        o_cmd       = '0;
        o_ready     = 1'b0;
        unique case (r_fsm)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_fsm      = ST_RUN;
                end
            end
            ST_RUN: begin
                if (i_status.finish) begin
                    if (w_out_free) begin
                        o_cmd.capture = 1'b1;
                        n_out_valid   = 1'b1;
                        n_fsm         = ST_IDLE;
                    end
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            default: begin
                n_fsm = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_fsm       <= n_fsm;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== hdl/lfsr_reverse_position_search.sv =====
// Sequence: the input state is loaded, stepped backward until a checkpoint or the seed is
// reached, and the final state is checked and the result registered once the output is free.
// A zero state, or one that meets neither within 131071 backward steps, is flagged invalid.
// Throughput: one transaction at a time; the single backward-stepping LFSR register sets it.
// A finished result may wait at the output while the next transaction is accepted.
// Reset is synchronous and active low; it clears the controller and the output valid flag.
`default_nettype none

`include "lfsr_reverse_position_search_macros.svh"

module lfsr_reverse_position_search (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  lrps_pkg::t_sel   i_poly_index,
    input  wire  lrps_pkg::t_state i_lfsr_state,
    output logic        o_valid,
    input  wire         i_ready,
    output lrps_pkg::t_state o_step_count,
    output logic        o_invalid
);

    lrps_pkg::t_cmd    w_cmd;
    lrps_pkg::t_status w_status;

    lrps_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    lrps_datapath u_datapath (
        .i_clk        (i_clk),
        .i_cmd        (w_cmd),
        .i_poly_index (i_poly_index),
        .i_lfsr_state (i_lfsr_state),
        .o_status     (w_status),
        .o_step_count (o_step_count),
        .o_invalid    (o_invalid)
    );

    `LRPS_ASSERT_SAME(a_invalid_zero, i_clk, i_rst_n, o_valid && o_invalid, o_step_count == '0, "invalid result with nonzero count")
    `LRPS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && o_ready, !o_ready, "ready held after a transaction was accepted")

endmodule

`default_nettype wire
